@@ hw/rtl/calam_pkg.sv @@
// Shared types, constants and the month-length function for calendar_add_months_clip.
package calam_pkg;

    localparam int YEAR_W      = 14;
    localparam int YEAR_OUT_W  = 15;
    // internal year is one bit wider so the leap and validity checks see the true year
    localparam int YEAR_MID_W  = 16;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int OFFSET_W    = 11;
    localparam int TOTAL_W     = 12;
    localparam int QUOT_W      = 8;

    // total months are biased by 100 years so the sum never goes negative
    localparam logic signed [12:0] MONTH_BIAS_M1 = 13'sd1199;
    localparam logic signed [YEAR_MID_W-1:0] YEAR_BIAS = 16'sd100;

    // x/3 == (x*683) >> 11 for x < 2048
    localparam logic [9:0]  RECIP3    = 10'd683;
    localparam int          RECIP3_SH = 11;
    // x/25 == (x*1311) >> 15 for x < 4681
    localparam logic [10:0] RECIP25    = 11'd1311;
    localparam int          RECIP25_SH = 15;

    localparam logic [MONTH_W-1:0] FEB = 4'd2;
    localparam logic [MONTH_W-1:0] APR = 4'd4;
    localparam logic [MONTH_W-1:0] JUN = 4'd6;
    localparam logic [MONTH_W-1:0] SEP = 4'd9;
    localparam logic [MONTH_W-1:0] NOV = 4'd11;
    localparam logic [MONTH_W-1:0] JAN = 4'd1;
    localparam logic [MONTH_W-1:0] DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic signed [OFFSET_W-1:0] offset;
    } start_t;

    typedef struct packed {
        logic signed [YEAR_MID_W-1:0] year;
        logic [MONTH_W-1:0]           month;
        logic [DAY_W-1:0]             day;
    } mid_t;

    typedef struct packed {
        logic signed [YEAR_OUT_W-1:0] year;
        logic [MONTH_W-1:0]           month;
        logic [DAY_W-1:0]             day;
        logic                         valid;
    } res_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            FEB:                len = leap ? 5'd29 : 5'd28;
            APR, JUN, SEP, NOV: len = 5'd30;
            default:            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/calam_month_stage.sv @@
// Month stage: adds the offset, splits into years and month, holds the result in a register.
module calam_month_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  calam_pkg::start_t in_data,
    output logic              out_valid,
    output calam_pkg::mid_t   out_data
);
    import calam_pkg::*;

    logic signed [12:0]          total_s;
    logic [TOTAL_W-1:0]          total;
    logic [19:0]                 prod3;
    logic [QUOT_W-1:0]           quot;
    logic [TOTAL_W-1:0]          quot_x12;
    logic [TOTAL_W-1:0]          rem_full;
    mid_t                        mid_next;
    mid_t                        mid_reg;
    logic                        valid_reg;

    always_comb begin
        total_s  = $signed({9'b0, in_data.month}) +
                   $signed({{2{in_data.offset[OFFSET_W-1]}}, in_data.offset}) + MONTH_BIAS_M1;
        total    = total_s[TOTAL_W-1:0];
        // total/12 as (total/4)/3
        prod3    = {10'b0, total[TOTAL_W-1:2]} * {10'b0, RECIP3};
        quot     = prod3[RECIP3_SH+QUOT_W-1:RECIP3_SH];
        quot_x12 = {1'b0, quot, 3'b0} + {2'b0, quot, 2'b0};
        rem_full = total - quot_x12;

        mid_next.year  = $signed({2'b0, in_data.year}) +
                         $signed({{(YEAR_MID_W-QUOT_W){1'b0}}, quot}) - YEAR_BIAS;
        mid_next.month = rem_full[MONTH_W-1:0] + JAN;
        mid_next.day   = in_data.day;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mid_reg <= mid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = mid_reg;

endmodule

@@ hw/rtl/calam_clip_stage.sv @@
// Clip stage: leap test, day clipping against month length, validity flag, result register.
module calam_clip_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           in_valid,
    input  calam_pkg::mid_t                in_data,
    input  logic [calam_pkg::YEAR_W-1:0]   first_valid_year,
    output logic                           out_valid,
    output calam_pkg::res_t                out_data
);
    import calam_pkg::*;

    logic [YEAR_MID_W-1:0] mag;
    logic [13:0]           quarter;
    logic [23:0]           prod25;
    logic [7:0]            q25;
    logic [13:0]           q25_x25;
    logic                  div4;
    logic                  div100;
    logic                  leap;
    logic [DAY_W-1:0]      dim;
    logic [DAY_W-1:0]      day_clip;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  valid_reg;

    always_comb begin
        // leap rule works on the magnitude of the year
        mag     = in_data.year[YEAR_MID_W-1] ? YEAR_MID_W'(-in_data.year)
                                             : in_data.year[YEAR_MID_W-1:0];
        quarter = mag[YEAR_MID_W-1:2];
        prod25  = {10'b0, quarter} * {13'b0, RECIP25};
        q25     = prod25[RECIP25_SH+7:RECIP25_SH];
        q25_x25 = {2'b0, q25, 4'b0} + {3'b0, q25, 3'b0} + {6'b0, q25};
        div4    = (mag[1:0] == 2'b00);
        div100  = div4 && (quarter == q25_x25);
        leap    = div4 && (!div100 || (q25[1:0] == 2'b00));

        dim      = month_len(in_data.month, leap);
        day_clip = (in_data.day > dim) ? dim : in_data.day;

        res_next.year  = in_data.year[YEAR_OUT_W-1:0];
        res_next.month = in_data.month;
        res_next.day   = day_clip;
        res_next.valid = (in_data.year >= $signed({2'b0, first_valid_year})) &&
                         (day_clip != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

@@ hw/rtl/calendar_add_months_clip.sv @@
// Top level: request channels, configuration register and the three-register pipeline.
// Adds a signed month offset to a Gregorian date, clipping the day to the new month's
// length, and flags whether the result is a valid date not earlier than first_valid_year.
// A new request is taken every cycle unless the pipeline is stalled and full; each request
// moves through the input register, the month stage register and the result register; a
// stalled result holds the pipeline only where registers are full. first_valid_year is
// written through the cfg channel, which is always ready; write it only while the block
// is idle.
module calendar_add_months_clip (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [calam_pkg::YEAR_W-1:0]        cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [calam_pkg::YEAR_W-1:0]        s_start_year,
    input  logic [calam_pkg::MONTH_W-1:0]       s_start_month,
    input  logic [calam_pkg::DAY_W-1:0]         s_start_day,
    input  logic signed [calam_pkg::OFFSET_W-1:0] s_month_offset,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [calam_pkg::YEAR_OUT_W-1:0] m_result_year,
    output logic [calam_pkg::MONTH_W-1:0]       m_result_month,
    output logic [calam_pkg::DAY_W-1:0]         m_result_day,
    output logic                                m_date_valid
);
    import calam_pkg::*;

    logic [YEAR_W-1:0] first_year_reg;
    start_t            start_next;
    start_t            start_reg;
    logic              start_valid_reg;
    logic              mid_valid;
    mid_t              mid_data;
    logic              res_valid;
    res_t              res_data;
    logic              adv_in;
    logic              adv_mid;
    logic              adv_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_year_reg <= YEAR_W'(1);
        end else if (cfg_valid) begin
            first_year_reg <= cfg_data;
        end
    end

    // each register moves on when empty or when the one after it moves
    assign adv_out = !res_valid || m_ready;
    assign adv_mid = !mid_valid || adv_out;
    assign adv_in  = !start_valid_reg || adv_mid;
    assign s_ready = adv_in;

    always_comb begin
        start_next.year   = s_start_year;
        start_next.month  = s_start_month;
        start_next.day    = s_start_day;
        start_next.offset = s_month_offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_valid_reg <= 1'b0;
        end else if (adv_in) begin
            start_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            start_reg <= start_next;
        end
    end

    calam_month_stage u_month (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv_mid),
        .in_valid  (start_valid_reg),
        .in_data   (start_reg),
        .out_valid (mid_valid),
        .out_data  (mid_data)
    );

    calam_clip_stage u_clip (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (adv_out),
        .in_valid         (mid_valid),
        .in_data          (mid_data),
        .first_valid_year (first_year_reg),
        .out_valid        (res_valid),
        .out_data         (res_data)
    );

    assign m_valid        = res_valid;
    assign m_result_year  = res_data.year;
    assign m_result_month = res_data.month;
    assign m_result_day   = res_data.day;
    assign m_date_valid   = res_data.valid;

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_month >= JAN && m_result_month <= DEC))
        else $error("result month out of range");

    a_day_zero_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_day == '0) |-> !m_date_valid)
        else $error("day zero flagged valid");

    a_feb_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_month == FEB) |-> (m_result_day <= 5'd29))
        else $error("february day not clipped");

    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

@@ dv/calendar_add_months_clip_tb.sv @@
// Self-checking testbench for calendar_add_months_clip: directed and randomised requests, checked results.
module calendar_add_months_clip_tb;

    import calam_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 400;
    localparam int RANDOM_BATCH = 200;
    localparam int DAYS_IN_MONTH [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int LEAP_PROBES [8] = '{100, 400, 1600, 1700, 1900, 2000, 2100, 2400};

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [YEAR_W-1:0]             cfg_data       = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [YEAR_W-1:0]             s_start_year   = '0;
    logic [MONTH_W-1:0]            s_start_month  = '0;
    logic [DAY_W-1:0]              s_start_day    = '0;
    logic signed [OFFSET_W-1:0]    s_month_offset = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic signed [YEAR_OUT_W-1:0]  m_result_year;
    logic [MONTH_W-1:0]            m_result_month;
    logic [DAY_W-1:0]              m_result_day;
    logic                          m_date_valid;

    start_t queued_requests [$];
    res_t   due_dates [$];
    start_t next_req;
    res_t   want;

    logic [YEAR_W-1:0] floor_year = 14'd1;
    int n_failures   = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_settings   = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int rx_cycle     = 0;
    int stall_mode   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int cycle_count  = 0;

    calendar_add_months_clip dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_year   (s_start_year),
        .s_start_month  (s_start_month),
        .s_start_day    (s_start_day),
        .s_month_offset (s_month_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_year  (m_result_year),
        .m_result_month (m_result_month),
        .m_result_day   (m_result_day),
        .m_date_valid   (m_date_valid)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // expected date for one request under the given floor year
    function automatic res_t shift_date(start_t d, logic [YEAR_W-1:0] lowest_year);
        res_t r;
        int total;
        int yr;
        int mag;
        int mlen;
        int day;
        bit leap;
        total   = int'(d.month) - 1 + int'(d.offset) + 1200;
        yr      = int'(d.year) + total / 12 - 100;
        r.month = 4'(total % 12 + 1);
        mag     = (yr < 0) ? -yr : yr;
        leap    = (mag % 4 == 0) && ((mag % 100 != 0) || (mag % 400 == 0));
        mlen    = DAYS_IN_MONTH[r.month];
        if (r.month == FEB && leap) mlen = 29;
        day = int'(d.day);
        if (day > mlen) day = mlen;
        r.year  = 15'(yr);
        r.day   = 5'(day);
        r.valid = (yr >= int'(lowest_year)) && (day >= 1);
        return r;
    endfunction

    function automatic start_t random_request();
        start_t r;
        int unsigned pick;
        pick     = $urandom_range(0, 9);
        r.year   = 14'($urandom_range(1, 9999));
        r.month  = 4'($urandom_range(1, 12));
        r.day    = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(28, 31))
                                               : 5'($urandom_range(1, 31));
        r.offset = 11'(int'($urandom_range(0, 72)) - 36);
        if (pick == 4 || pick == 5) begin
            r.offset = 11'(int'($urandom_range(0, 2046)) - 1023);
        end else if (pick == 6 || pick == 7) begin
            // land near February of a century or a plain leap year
            r.year   = 14'(LEAP_PROBES[$urandom_range(0, 7)] + int'($urandom_range(0, 8)) - 4);
            r.month  = 4'($urandom_range(1, 3));
            r.day    = 5'($urandom_range(28, 31));
            r.offset = 11'(int'($urandom_range(0, 4)) - 2);
        end else if (pick == 8) begin
            // early years pulled back by 72 to 86 years, mostly to zero and below
            r.year   = 14'($urandom_range(0, 90));
            r.offset = 11'(int'($urandom_range(0, 150)) - 1024);
        end else if (pick == 9) begin
            r.year   = 14'($urandom);
            r.month  = 4'($urandom);
            r.day    = 5'($urandom);
            r.offset = 11'($urandom);
        end
        return r;
    endfunction

    task automatic queue_request(input int y, input int m, input int d, input int o);
        start_t r;
        r.year   = 14'(y);
        r.month  = 4'(m);
        r.day    = 5'(d);
        r.offset = 11'(o);
        queued_requests.push_back(r);
    endtask

    task automatic queue_directed();
        queue_request(1, 1, 1, 0);
        queue_request(16383, 15, 31, 1023);
        queue_request(0, 0, 0, -1024);
        queue_request(2023, 1, 31, 1);
        queue_request(2024, 1, 31, 1);
        queue_request(1900, 3, 31, -1);
        queue_request(2000, 3, 30, -1);
        queue_request(2100, 12, 29, 2);
        queue_request(2022, 0, 15, 0);      // month zero is December before
        queue_request(2022, 13, 10, 0);
        queue_request(2022, 15, 31, 0);
        queue_request(2022, 6, 0, 3);       // day zero passes through, invalid
        queue_request(2021, 4, 31, 0);      // start already past month end
        queue_request(2021, 11, 31, 12);
        queue_request(1, 1, 1, -1);         // into year zero
        queue_request(0, 2, 29, 0);
        queue_request(1, 2, 29, -60);       // negative leap year
        queue_request(3, 3, 31, -13);
        queue_request(9999, 12, 31, 1);
        queue_request(9999, 1, 15, -1023);
        queue_request(1, 1, 1, 1023);
        queue_request(400, 2, 29, 12);
        queue_request(2020, 2, 29, 48);
        queue_request(2000, 1, 1, -12);
    endtask

    task automatic queue_random(input int count);
        repeat (count) queued_requests.push_back(random_request());
    endtask

    task automatic drain();
        while (queued_requests.size() != 0 || due_dates.size() != 0) @(posedge aclk);
    endtask

    task automatic set_floor(input logic [YEAR_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        floor_year = value;
        n_settings++;
    endtask

    task automatic note_failure(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        n_failures++;
    endtask

    // request driver: bursts of random length, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) n_accepted++;
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || queued_requests.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_req = queued_requests.pop_front();
                    due_dates.push_back(shift_date(next_req, floor_year));
                    s_start_year   <= next_req.year;
                    s_start_month  <= next_req.month;
                    s_start_day    <= next_req.day;
                    s_month_offset <= next_req.offset;
                    s_valid        <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result monitor and output stall pattern
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (due_dates.size() == 0) begin
                    note_failure("result with no request outstanding");
                end else begin
                    want = due_dates.pop_front();
                    if (m_result_year !== want.year)
                        note_failure($sformatf("year %0d, expected %0d",
                                               m_result_year, want.year));
                    if (m_result_month !== want.month)
                        note_failure($sformatf("month %0d, expected %0d",
                                               m_result_month, want.month));
                    if (m_result_day !== want.day)
                        note_failure($sformatf("day %0d, expected %0d",
                                               m_result_day, want.day));
                    if (m_date_valid !== want.valid)
                        note_failure($sformatf("valid flag %0b, expected %0b",
                                               m_date_valid, want.valid));
                end
            end
            rx_cycle++;
            if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
            // one long hold-off so the pipeline fills and pushes back
            if (!hold_done && n_results >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (rx_cycle % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset value of the floor year first
        queue_directed();
        drain();

        set_floor(14'd0);
        queue_directed();
        queue_random(RANDOM_BATCH);
        drain();

        set_floor(14'd16383);
        queue_random(RANDOM_BATCH);
        drain();

        set_floor(14'd9999);
        queue_random(RANDOM_BATCH);
        drain();

        set_floor(14'($urandom_range(1, 9999)));
        queue_random(RANDOM_BATCH);
        drain();

        set_floor(14'd1);
        queue_random(RANDOM_BATCH);
        drain();

        set_floor(14'd2000);
        queue_random(RANDOM_BATCH);
        drain();

        repeat (10) @(posedge aclk);
        $display("Checked %0d of %0d date requests over %0d floor-year writes",
                 n_results, n_accepted, n_settings);
        $display("Included one %0d-cycle output hold-off and random stalls on both sides",
                 HOLD_CYCLES);
        if (n_failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
